/* design/lkv_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// No dependencies; compiled first.
package lkv_pkg;

  // Store geometry
  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int OCC_W   = $clog2(ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // Request kinds
  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_t;

  // Contents of one cell
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Command broadcast from the control to every cell
  typedef struct packed {
    logic             exec;
    logic             put;
    logic             evict;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_cmd_t;

  // Lookup status returned by the cell row
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } lkv_look_t;

endpackage

/* design/lkv_if.sv */
// Channel interfaces of the LRU key-value cache: request, result, configuration.
// Depends on lkv_pkg.
interface lkv_req_if import lkv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [KEY_W-1:0]        key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] value_out;

  modport source (output valid, hit, value_out, input ready);
  modport sink   (input valid, hit, value_out, output ready);
endinterface

interface lkv_cfg_if import lkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

/* design/lkv_cell.sv */
// One cell of the recency-ordered row: holds a single key/value entry.
// Depends on lkv_pkg.
module lkv_cell import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lkv_cmd_t         cmd,
  input  logic             any_hit,
  input  entry_t           prev_entry,
  input  logic             match_after_in,
  input  logic [VAL_W-1:0] hitval_in,
  output entry_t           entry,
  output logic             match,
  output logic             match_after_out,
  output logic [VAL_W-1:0] hitval_out
);

  logic load;

  // Key compare and hit chains toward the head
  assign match           = entry.valid && (entry.key == cmd.key);
  assign match_after_out = match || match_after_in;
  assign hitval_out      = hitval_in | ({VAL_W{match}} & entry.value);

  // Shift from the more recent neighbor:
  //   hit  - every cell up to and including the hit one
  //   miss put - every valid cell, plus the first free one unless evicting
  always_comb begin
    load = 1'b0;
    if (cmd.exec) begin
      if (any_hit) begin
        load = match_after_out;
      end else if (cmd.put) begin
        load = entry.valid || (prev_entry.valid && !cmd.evict);
      end
    end
  end

  // Entry register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (load) begin
      entry.valid <= prev_entry.valid;
    end
    if (load) begin
      entry.key   <= prev_entry.key;
      entry.value <= prev_entry.value;
    end
  end

endmodule

/* design/lkv_chain.sv */
// Row of cells ordered by recency: cell 0 is most recent.
// Depends on lkv_pkg and lkv_cell.
module lkv_chain import lkv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  lkv_cmd_t               cmd,
  output lkv_look_t              look,
  output logic [ENTRIES-1:0]     valid_vec
);

  entry_t             cell_entry [ENTRIES];
  entry_t             head_entry;
  logic               match_chain [ENTRIES+1];
  logic [VAL_W-1:0]   hitval_chain [ENTRIES+1];
  logic [ENTRIES-1:0] match_vec;

  assign match_chain[ENTRIES]  = 1'b0;
  assign hitval_chain[ENTRIES] = '0;

  assign look.hit   = match_chain[0];
  assign look.value = hitval_chain[0];

  // New head: the request key with the put value, or the hit entry's value on a get
  assign head_entry.valid = 1'b1;
  assign head_entry.key   = cmd.key;
  assign head_entry.value = cmd.put ? cmd.value : hitval_chain[0];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t prev;
    if (i == 0) begin : g_head
      assign prev = head_entry;
    end else begin : g_body
      assign prev = cell_entry[i-1];
    end

    lkv_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .cmd             (cmd),
      .any_hit         (match_chain[0]),
      .prev_entry      (prev),
      .match_after_in  (match_chain[i+1]),
      .hitval_in       (hitval_chain[i+1]),
      .entry           (cell_entry[i]),
      .match           (match_vec[i]),
      .match_after_out (match_chain[i]),
      .hitval_out      (hitval_chain[i])
    );

    assign valid_vec[i] = cell_entry[i].valid;
  end

  // A key lives in at most one cell
  a_single_match: assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("key matches more than one cell");

  // Valid cells form an unbroken run from the head
  a_packed_valid: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("gap in the valid cells");

  // A get that misses leaves the row untouched
  a_miss_stable: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !cmd.put && !look.hit |=> $stable(valid_vec))
    else $error("get miss changed the row");

endmodule

/* design/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: request register, occupancy, result register.
// Depends on lkv_pkg, lkv_if and lkv_chain.
//
// Usage:
//   req carries kind (0 get, 1 put), key and value. A request is taken when
//   req.valid and req.ready are both high. One request is in flight at a time:
//   it is registered in the cycle it is taken and applied to the cell row in the
//   next, unless a get waits for room in the result register; no new request is
//   taken until the held one is applied, with full-row key compare plus recency shift.
//   rsp returns hit and value_out for every get (value_out is -1 on a miss),
//   registered: rsp.valid rises after the request has passed the request register
//   and been applied to the cell row. A put returns nothing.
//   If the receiver holds rsp.ready low, the result waits in the output
//   register; the next request may still be taken, but a following get is held
//   in the request register until the pending result has been taken.
//   cfg writes capacity_in_use whenever cfg.valid is high (ready is always high);
//   write it only while no request is in flight.
//   Reset (rst, synchronous) empties the store and sets the capacity to 16;
//   the block takes requests in the first cycle after reset.
module lru_key_value_cache import lkv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lkv_req_if.sink   req,
  lkv_rsp_if.source rsp,
  lkv_cfg_if.sink   cfg
);

  logic               busy;
  kind_t              req_kind;
  logic [KEY_W-1:0]   req_key;
  logic [VAL_W-1:0]   req_value;
  logic [CAP_W-1:0]   capacity;
  logic [CAP_W-1:0]   eff_cap;
  logic [OCC_W-1:0]   occupancy;
  logic               rsp_valid;
  logic               rsp_hit;
  logic [VAL_W-1:0]   rsp_value;
  lkv_cmd_t           cmd;
  lkv_look_t          look;
  logic [ENTRIES-1:0] valid_vec;

  // Configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.capacity_in_use;
    end
  end

  // Capacity of zero acts as one; above the row length it saturates
  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (32'(capacity) > ENTRIES) begin
      eff_cap = CAP_W'(ENTRIES);
    end
  end

  // Request register
  assign req.ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.valid && req.ready) begin
      busy <= 1'b1;
    end else if (cmd.exec) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_kind  <= kind_t'(req.kind);
      req_key   <= req.key;
      req_value <= req.value;
    end
  end

  // Apply the held request; a get waits for room in the result register
  always_comb begin
    cmd.exec  = busy && (req_kind == KIND_PUT || !rsp_valid || rsp.ready);
    cmd.put   = (req_kind == KIND_PUT);
    cmd.evict = (32'(occupancy) >= 32'(eff_cap));
    cmd.key   = req_key;
    cmd.value = req_value;
  end

  lkv_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .look      (look),
    .valid_vec (valid_vec)
  );

  // Occupancy grows only on an insert without eviction
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.exec && cmd.put && !look.hit && !cmd.evict) begin
      occupancy <= occupancy + OCC_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec && !cmd.put) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !cmd.put) begin
      rsp_hit   <= look.hit;
      rsp_value <= look.hit ? look.value : MISS_VALUE;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.hit       = rsp_hit;
  assign rsp.value_out = rsp_value;

  // Occupancy tracks the number of valid cells
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    32'($countones(valid_vec)) == 32'(occupancy))
    else $error("occupancy out of step with valid cells");

  // Every applied get produces a result in the next cycle
  a_get_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !cmd.put |=> rsp_valid)
    else $error("get produced no result");

  // A put to a present key never changes occupancy
  a_update_occ: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && cmd.put && look.hit |=> $stable(occupancy))
    else $error("update changed occupancy");

endmodule
